// ===== hw/rtl/ascii_decimal_to_fixed_parser_defines.svh =====
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_parser_defines.svh
// Assertion macros shared by the parser checks. Each macro expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_TO_FIXED_PARSER_DEFINES_SVH
`define ASCII_DECIMAL_TO_FIXED_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ADFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ADFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/adfp_pkg.sv =====
// ----------------------------------------------------------------------------
// adfp_pkg
// Types and constants of the ASCII decimal to fixed point parser.
// ----------------------------------------------------------------------------
package adfp_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NO_NUMBER = 2'd3
  } status_t;

  // One result entry
  typedef struct packed {
    logic [63:0] value;
    status_t     status;
    logic        last;
  } result_t;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Magnitude limits
  localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

  // Fraction digit weights floor(2^32 / 10^k), k = 0..10
  localparam int unsigned FCNT_MAX_I = 10;
  localparam logic [3:0]  FCNT_MAX   = 4'd10;
  localparam logic [32:0] SCALE_TBL [0:FCNT_MAX_I] = '{
    33'd4294967296, 33'd429496729, 33'd42949672, 33'd4294967, 33'd429496,
    33'd42949, 33'd4294, 33'd429, 33'd42, 33'd4, 33'd0
  };

  // Result queue
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

endpackage

// ===== hw/rtl/ascii_decimal_to_fixed_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_parser
// Parses a stream of ASCII characters, one per request, into signed fixed
// point numbers with FRAC_BITS fraction bits (Q31.32 by default).
// Input: in_valid/in_stall carrying in_ch and in_end_of_text. Output:
// out_valid/out_stall carrying out_value, out_status and out_last.
// A request gives zero, one or two results; out_last marks the final one.
// Results are written into a four-entry result queue when the request is
// taken and leave from its head, one per cycle while out_stall is low. One
// character is taken per cycle while in_stall is low; in_stall rises when
// fewer than two entries are free. While out_stall is high the queue head
// holds still and input continues until fewer than two entries are free.
// Reset (synchronous, rst_n low) empties the queue and returns the parser
// to seeking the start of a number.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_parser #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_end_of_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import adfp_pkg::*;

  localparam int unsigned SCALE_SHIFT = 32 - FRAC_BITS;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic        ovf_r, ovf_nxt;

  // Result queue
  result_t           q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;

  logic in_fire, out_fire;

  // Character classes
  logic       is_digit, is_delim, is_dot;
  logic [3:0] digit;
  logic [63:0] digit_fix;

  // Seek decode from a cleared state
  phase_t      seek_phase;
  logic        seek_neg, seek_bad;
  logic [63:0] seek_acc;

  // Arithmetic
  logic [63:0] lim;
  logic [67:0] int_sum, frac_sum;
  logic        sat_int, sat_frac;
  logic [3:0]  fidx;
  logic [32:0] scale;
  logic [36:0] frac_add;

  // Results of this request
  result_t    num_res, bad_res, res_a, res_b;
  logic [1:0] nres;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (cnt_r > Q_CW'(Q_DEPTH - 2));

  // Character classification
  assign is_digit  = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign is_dot    = (in_ch == CH_DOT);
  assign is_delim  = (in_ch == CH_COMMA) || (in_ch == CH_SPACE) ||
                     ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
  assign digit     = 4'(in_ch - CH_ZERO);
  assign digit_fix = {60'd0, digit} << FRAC_BITS;

  // Start of a number
  always_comb begin
    seek_phase = PH_SEEK;
    seek_neg   = 1'b0;
    seek_bad   = 1'b0;
    seek_acc   = '0;
    priority if (is_delim) begin
      seek_phase = PH_SEEK;
    end else if (in_ch == CH_PLUS) begin
      seek_phase = PH_INT;
    end else if (in_ch == CH_MINUS) begin
      seek_phase = PH_INT;
      seek_neg   = 1'b1;
    end else if (is_dot) begin
      seek_phase = PH_FRAC;
    end else if (is_digit) begin
      seek_phase = PH_INT;
      seek_acc   = digit_fix;
    end else begin
      seek_bad = 1'b1;
    end
  end

  // Saturating accumulate: integer digit (acc * 10 + d) and fraction digit
  assign lim      = neg_r ? LIM_NEG : LIM_POS;
  assign int_sum  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {4'd0, digit_fix};
  assign sat_int  = int_sum > {4'd0, lim};
  assign fidx     = (fcnt_r >= FCNT_MAX) ? FCNT_MAX : fcnt_r + 4'd1;
  assign scale    = SCALE_TBL[fidx] >> SCALE_SHIFT;
  assign frac_add = 37'(scale) * 37'(digit);
  assign frac_sum = {4'd0, acc_r} + 68'(frac_add);
  assign sat_frac = frac_sum > {4'd0, lim};

  // Result templates
  always_comb begin
    num_res.value  = neg_r ? 64'(64'd0 - acc_r) : acc_r;
    num_res.status = ovf_r ? ST_OVERFLOW : ST_OK;
    num_res.last   = 1'b0;
    bad_res.value  = '0;
    bad_res.status = ST_BAD_START;
    bad_res.last   = 1'b1;
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_end_of_text) begin
      phase_nxt = PH_SEEK;
    end else begin
      unique case (phase_r)
        PH_INT: begin
          if (is_digit)    phase_nxt = PH_INT;
          else if (is_dot) phase_nxt = PH_FRAC;
          else             phase_nxt = seek_phase;
        end
        PH_FRAC: begin
          if (is_digit) phase_nxt = PH_FRAC;
          else          phase_nxt = seek_phase;
        end
        default: phase_nxt = seek_phase;
      endcase
    end
  end

  // Datapath and results
  always_comb begin
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    fcnt_nxt = fcnt_r;
    ovf_nxt  = ovf_r;
    nres     = 2'd0;
    res_a    = num_res;
    res_b    = bad_res;
    if (in_end_of_text) begin
      // flush any pending number, else report an empty end
      if ((phase_r == PH_INT) || (phase_r == PH_FRAC)) begin
        res_a = num_res;
      end else begin
        res_a.value  = '0;
        res_a.status = ST_NO_NUMBER;
      end
      nres     = 2'd1;
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      fcnt_nxt = '0;
      ovf_nxt  = 1'b0;
    end else begin
      unique case (phase_r)
        PH_INT, PH_FRAC: begin
          if (is_digit && (phase_r == PH_INT)) begin
            acc_nxt = sat_int ? lim : int_sum[63:0];
            ovf_nxt = ovf_r | sat_int;
          end else if (is_digit) begin
            acc_nxt  = sat_frac ? lim : frac_sum[63:0];
            ovf_nxt  = ovf_r | sat_frac;
            fcnt_nxt = (fcnt_r >= FCNT_MAX) ? FCNT_MAX : fcnt_r + 4'd1;
          end else if (is_dot && (phase_r == PH_INT)) begin
            acc_nxt = acc_r;
          end else begin
            // terminator: emit, then restart on this character
            res_a    = num_res;
            nres     = seek_bad ? 2'd2 : 2'd1;
            acc_nxt  = seek_acc;
            neg_nxt  = seek_neg;
            fcnt_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end
        default: begin
          acc_nxt  = seek_acc;
          neg_nxt  = seek_neg;
          fcnt_nxt = '0;
          ovf_nxt  = 1'b0;
          if (seek_bad) begin
            res_a = bad_res;
            nres  = 2'd1;
          end
        end
      endcase
    end
    res_a.last = (nres == 2'd1);
    res_b.last = 1'b1;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      fcnt_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      fcnt_r  <= fcnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= wr_ptr_r + Q_AW'(nres);
      if (out_fire) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (in_fire ? Q_CW'(nres) : Q_CW'(0)) - Q_CW'(out_fire);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (in_fire && (nres != 2'd0)) q_mem[wr_ptr_r] <= res_a;
    if (in_fire && (nres == 2'd2)) q_mem[wr_ptr_r + 1'b1] <= res_b;
  end

  // Queue head drives the result channel
  assign out_valid  = (cnt_r != '0);
  assign out_value  = q_mem[rd_ptr_r].value;
  assign out_status = q_mem[rd_ptr_r].status;
  assign out_last   = q_mem[rd_ptr_r].last;

endmodule

// ===== hw/rtl/adfp_checker.sv =====
// ----------------------------------------------------------------------------
// adfp_checker
// Port-level checks of the ASCII decimal parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ascii_decimal_to_fixed_parser_defines.svh"

module adfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_ch,
  input logic               in_end_of_text,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] out_value,
  input logic [1:0]         out_status,
  input logic               out_last
);
  import adfp_pkg::*;

  // A stalled result holds
  `ADFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_value) && $stable(out_status) &&
                    $stable(out_last), "stalled result changed")

  // Error results carry a zero value
  `ADFP_ASSERT_NOW(a_err_zero,
                   out_valid && ((out_status == ST_BAD_START) ||
                                 (out_status == ST_NO_NUMBER)),
                   out_value == 64'sd0, "error result with nonzero value")

  // Bad start and empty end are always the final result of a request
  `ADFP_ASSERT_NOW(a_err_last,
                   out_valid && ((out_status == ST_BAD_START) ||
                                 (out_status == ST_NO_NUMBER)),
                   out_last, "error result not marked last")

  // Overflow results sit at a saturation limit
  `ADFP_ASSERT_NOW(a_ovf_sat, out_valid && (out_status == ST_OVERFLOW),
                   (out_value == LIM_POS) || (out_value == LIM_NEG),
                   "overflow result not saturated")

endmodule

bind ascii_decimal_to_fixed_parser adfp_checker u_adfp_checker (.*);

// ===== sim/ascii_decimal_to_fixed_parser_checker.sv =====
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_parser_checker
// Watches both channels of the parser. Every accepted character request runs
// through a local copy of the parse rules, and the results that it should
// cause are queued. Every accepted result is compared field by field with the
// oldest queued one. Failures and outstanding results are handed to the top.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_parser_checker #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_end_of_text,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [63:0] out_value,
  input  logic [1:0]         out_status,
  input  logic               out_last,
  output int                 mismatch_count,
  output int                 awaited_count,
  output int                 results_checked,
  output int                 overflow_seen,
  output int                 bad_start_seen,
  output int                 no_number_seen
);
  import adfp_pkg::*;

  // Parser state as predicted
  phase_t      num_phase;
  logic [63:0] magnitude;
  logic        is_neg;
  logic [32:0] frac_weight;
  logic        saturated;

  // Results of the current request, then the store of results still due
  result_t fresh_results[$];
  result_t expected_results[$];

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_COMMA || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_number();
    num_phase   = PH_SEEK;
    magnitude   = '0;
    is_neg      = 1'b0;
    frac_weight = 33'd1 << FRAC_BITS;
    saturated   = 1'b0;
  endtask

  task automatic add_result(input logic [63:0] value, input status_t status);
    result_t r;
    r.value  = value;
    r.status = status;
    r.last   = 1'b0;
    fresh_results.push_back(r);
  endtask

  // magnitude = magnitude * mul + addend, clamped at the limit of the sign
  task automatic accumulate(input logic [63:0] mul, input logic [63:0] addend);
    logic [63:0] lim;
    lim = is_neg ? LIM_NEG : LIM_POS;
    if (addend > lim || magnitude > (lim - addend) / mul) begin
      magnitude = lim;
      saturated = 1'b1;
    end else begin
      magnitude = magnitude * mul + addend;
    end
  endtask

  task automatic emit_number();
    add_result(is_neg ? 64'd0 - magnitude : magnitude, saturated ? ST_OVERFLOW : ST_OK);
    clear_number();
  endtask

  // Character seen while looking for the start of a number
  task automatic seek_start(input logic [7:0] c);
    if (is_delim(c)) begin
      return;
    end else if (c == CH_PLUS) begin
      num_phase = PH_INT;
    end else if (c == CH_MINUS) begin
      is_neg    = 1'b1;
      num_phase = PH_INT;
    end else if (c == CH_DOT) begin
      num_phase = PH_FRAC;
    end else if (is_digit(c)) begin
      num_phase = PH_INT;
      accumulate(64'd10, 64'(c - CH_ZERO) << FRAC_BITS);
    end else begin
      add_result('0, ST_BAD_START);
    end
  endtask

  // Predict the results of one character request
  task automatic parse_request(input logic [7:0] c, input logic eot);
    result_t tail;
    fresh_results.delete();
    if (eot) begin
      if (num_phase == PH_INT || num_phase == PH_FRAC) emit_number();
      else add_result('0, ST_NO_NUMBER);
      clear_number();
    end else begin
      case (num_phase)
        PH_INT: begin
          if (is_digit(c)) accumulate(64'd10, 64'(c - CH_ZERO) << FRAC_BITS);
          else if (c == CH_DOT) num_phase = PH_FRAC;
          else begin
            emit_number();
            seek_start(c);
          end
        end
        PH_FRAC: begin
          if (is_digit(c)) begin
            frac_weight = frac_weight / 33'd10;
            accumulate(64'd1, 64'(frac_weight) * 64'(c - CH_ZERO));
          end else begin
            emit_number();
            seek_start(c);
          end
        end
        default: begin
          num_phase = PH_SEEK;
          seek_start(c);
        end
      endcase
    end
    // last marks the final result of the request
    if (fresh_results.size() > 0) begin
      tail      = fresh_results.pop_back();
      tail.last = 1'b1;
      fresh_results.push_back(tail);
    end
    foreach (fresh_results[i]) expected_results.push_back(fresh_results[i]);
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: value %0d status %0d last %0b",
                 out_value, out_status, out_last);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      case (want.status)
        ST_OVERFLOW:  overflow_seen++;
        ST_BAD_START: bad_start_seen++;
        ST_NO_NUMBER: no_number_seen++;
        default: ;
      endcase
      if (out_value !== want.value || out_status !== want.status || out_last !== want.last)
      begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: expected value %0d status %0d last %0b, got %0d %0d %0b",
                   results_checked, $signed(want.value), want.status, want.last,
                   out_value, out_status, out_last);
      end
    end
  endtask

  // Predict before comparing, so a result of this same edge would be found
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_number();
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) parse_request(in_ch, in_end_of_text);
      if (out_valid && !out_stall) check_result();
    end
    awaited_count = expected_results.size();
  end

endmodule

// ===== sim/ascii_decimal_to_fixed_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_parser_tb
// Feeds the parser directed character strings (sign or dot alone, terminator
// restarts, end of text, the negative limit and saturation), then random
// number text with noise, under random idling on both channels. Results are
// checked by the checker module; this top gives the verdict.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_parser_tb;
  import adfp_pkg::*;

  localparam int unsigned FRAC_BITS    = 32;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 16;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_ch;
  logic               in_end_of_text;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] out_value;
  logic [1:0]         out_status;
  logic               out_last;

  int mismatch_count;
  int awaited_count;
  int results_checked;
  int overflow_seen;
  int bad_start_seen;
  int no_number_seen;

  int   requests_sent;
  int   filler_sent;
  int   quiet_cycles;
  logic no_gaps;

  ascii_decimal_to_fixed_parser #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ch         (in_ch),
    .in_end_of_text(in_end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  ascii_decimal_to_fixed_parser_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .results_checked(results_checked),
    .overflow_seen  (overflow_seen),
    .bad_start_seen (bad_start_seen),
    .no_number_seen (no_number_seen)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver stalls at random, never during the steady stretch
  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < 34);
  end

  // Watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ascii_decimal_to_fixed_parser_tb: FAIL");
        $finish;
      end
    end
  end

  // One character request; called at a falling edge, returns at one
  task automatic send_byte(input logic [7:0] c, input logic eot);
    while (!no_gaps && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_ch          <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Hold the sender off until every due result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_COMMA;
      default: return CH_TAB + 8'($urandom_range(0, 4));
    endcase
  endfunction

  // Any byte that cannot start a number and is not a delimiter
  function automatic logic [7:0] pick_bad_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
               c == CH_DOT || c == CH_COMMA || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
    return c;
  endfunction

  // A well formed number with random content and a random terminator or none
  task automatic send_number(input logic long_form);
    int n_int;
    int n_frac;
    int pick;
    logic has_sign;
    logic has_dot;
    pick     = $urandom_range(0, 3);
    has_sign = pick < 2;
    if (pick == 0) send_byte(CH_PLUS, 1'b0);
    else if (pick == 1) send_byte(CH_MINUS, 1'b0);
    n_int   = long_form ? $urandom_range(10, 14) : $urandom_range(0, 4);
    has_dot = $urandom_range(0, 2) != 0;
    n_frac  = !has_dot ? 0 : ($urandom_range(0, 5) == 0 ? $urandom_range(5, 13)
                                                       : $urandom_range(0, 4));
    if (!has_sign && !has_dot && n_int == 0) n_int = 1;
    repeat (n_int) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    if (has_dot) send_byte(CH_DOT, 1'b0);
    repeat (n_frac) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    pick = $urandom_range(0, 99);
    if (pick < 45) send_byte(pick_delim(), 1'b0);
    else if (pick < 60) send_byte(pick_bad_char(), 1'b0);
    else if (pick < 72) begin
      case ($urandom_range(0, 2))
        0:       send_byte(CH_PLUS, 1'b0);
        1:       send_byte(CH_MINUS, 1'b0);
        default: send_byte(CH_DOT, 1'b0);
      endcase
    end else if (pick < 85) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 62) send_number(1'b0);
    else if (pick < 70) send_number(1'b1);
    else if (pick < 80) send_byte(8'($urandom_range(0, 255)), 1'b0);
    else if (pick < 88) send_byte(8'($urandom_range(0, 255)), 1'b1);
    else begin
      // delimiters only, the parser skips them once no number is pending
      n = $urandom_range(1, 3);
      repeat (n) send_byte(pick_delim(), 1'b0);
      filler_sent += n;
    end
  endtask

  // Stimulus and verdict
  initial begin
    int base;
    int progress;
    logic early_pause_done;
    logic late_pause_done;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_ch            = '0;
    in_end_of_text   = 1'b0;
    no_gaps          = 1'b0;
    requests_sent    = 0;
    filler_sent      = 0;
    early_pause_done = 1'b0;
    late_pause_done  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: restart on terminator with a bad start behind it
    send_text("-1.5x");
    // sign alone, then dot alone closed by end of text
    send_text("+,");
    send_byte(CH_DOT, 1'b0);
    send_byte(8'h00, 1'b1);
    // end of text with nothing pending, then bad starts at both byte extremes
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // exactly the negative limit, then one more digit saturates
    send_text("-21474836489");
    send_byte(CH_CR, 1'b0);
    drain_results();

    // Random number text
    base = requests_sent;
    progress = 0;
    while (progress < RANDOM_ITEMS) begin
      no_gaps = progress >= 250 && progress < 370;
      if (!early_pause_done && progress >= 150) begin
        drain_results();
        early_pause_done = 1'b1;
      end
      if (!late_pause_done && progress >= 450) begin
        drain_results();
        late_pause_done = 1'b1;
      end
      send_random_token();
      progress = requests_sent - base - filler_sent;
    end
    no_gaps = 1'b0;

    // Let every result out, then watch for strays
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d character requests sent, %0d results checked", requests_sent,
             results_checked);
    $display("%0d saturated, %0d bad starts, %0d empty end-of-text results",
             overflow_seen, bad_start_seen, no_number_seen);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("ascii_decimal_to_fixed_parser_tb: PASS");
    end else begin
      $display("ascii_decimal_to_fixed_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
